>>> hdl/ihex_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ihex_pkg
// Shared types and constants of the Intel HEX record parser.
// ----------------------------------------------------------------------------
package ihex_pkg;

  localparam int MAX_RECORD_BYTES = 16;
  localparam int CNT_W            = $clog2(MAX_RECORD_BYTES + 1);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic KIND_DATA  = 1'b0;
  localparam logic KIND_CHECK = 1'b1;

  typedef struct packed {
    logic [7:0] value;
    logic       bad;
  } byte_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  byte_value;
    logic [7:0]  record_type;
    logic [15:0] record_address;
    logic [3:0]  byte_index;
    logic        bad_digit;
  } result_t;

endpackage : ihex_pkg
`default_nettype wire

>>> hdl/ihex_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ihex_front
// Character decode: skip line breaks and colons, pair other characters into bytes and flag non-hex digits.
// ----------------------------------------------------------------------------
module ihex_front (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  char_valid,
  input  wire  [7:0]           char_in,
  output logic                 byte_push,
  output ihex_pkg::byte_item_t byte_item
);
  import ihex_pkg::*;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_COLON = 8'h3A;

  logic       second_r, second_nxt;
  logic [3:0] high_r, high_nxt;
  logic       bad_r, bad_nxt;
  logic       skip;
  logic       is_digit;
  logic       is_upper;
  logic       is_lower;
  logic       ok;
  logic [3:0] nib;

  assign skip     = (char_in == CHAR_CR) || (char_in == CHAR_LF) || (char_in == CHAR_COLON);
  assign is_digit = (char_in >= 8'h30) && (char_in <= 8'h39);
  assign is_upper = (char_in >= 8'h41) && (char_in <= 8'h46);
  assign is_lower = (char_in >= 8'h61) && (char_in <= 8'h66);
  assign ok       = is_digit || is_upper || is_lower;

  always_comb begin
    priority if (is_digit) begin
      nib = char_in[3:0];
    end else if (is_upper || is_lower) begin
      nib = char_in[3:0] + 4'd9;
    end else begin
      nib = 4'd0;
    end
  end

  always_comb begin
    second_nxt = second_r;
    high_nxt   = high_r;
    bad_nxt    = bad_r;
    byte_push  = 1'b0;
    if (char_valid && !skip) begin
      if (!second_r) begin
        high_nxt   = nib;
        bad_nxt    = !ok;
        second_nxt = 1'b1;
      end else begin
        byte_push  = 1'b1;
        bad_nxt    = 1'b0;
        second_nxt = 1'b0;
      end
    end
  end

  assign byte_item.value = {high_r, nib};
  assign byte_item.bad   = bad_r || !ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      second_r <= 1'b0;
      high_r   <= 4'd0;
      bad_r    <= 1'b0;
    end else begin
      second_r <= second_nxt;
      high_r   <= high_nxt;
      bad_r    <= bad_nxt;
    end
  end

endmodule : ihex_front
`default_nettype wire

>>> hdl/ihex_byte_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ihex_byte_fifo
// Short queue of assembled bytes between the decoder and the field sequencer.
// ----------------------------------------------------------------------------
module ihex_byte_fifo (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  push,
  input  ihex_pkg::byte_item_t push_item,
  output logic                 full,
  output logic                 valid,
  input  wire                  pop,
  output ihex_pkg::byte_item_t pop_item
);
  import ihex_pkg::*;

  byte_item_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    if (p == QPTR_W'(QDEPTH - 1)) begin
      return '0;
    end
    return p + QPTR_W'(1);
  endfunction

  assign full     = (count_r == QCNT_W'(QDEPTH));
  assign valid    = (count_r != '0);
  assign pop_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop  ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule : ihex_byte_fifo
`default_nettype wire

>>> hdl/ihex_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ihex_back
// Field sequencer: place bytes into record fields and hold the result.
// ----------------------------------------------------------------------------
module ihex_back (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  byte_valid,
  input  ihex_pkg::byte_item_t byte_item,
  output logic                 byte_pop,
  output logic                 res_valid,
  input  wire                  res_pop,
  output ihex_pkg::result_t    res
);
  import ihex_pkg::*;

  typedef enum logic [2:0] {
    ST_COUNT,
    ST_ADDR_HI,
    ST_ADDR_LO,
    ST_TYPE,
    ST_DATA,
    ST_CHECK
  } stage_t;

  stage_t            stage_r;
  logic [CNT_W-1:0]  data_count_r;
  logic [CNT_W-1:0]  data_pos_r;
  logic [CNT_W-1:0]  pos_inc;
  logic [15:0]       addr_r;
  logic [7:0]        type_r;
  logic              res_valid_r;
  result_t           res_r;

  assign byte_pop  = byte_valid && (!res_valid_r || res_pop);
  assign res_valid = res_valid_r;
  assign res       = res_r;
  assign pos_inc   = data_pos_r + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r      <= ST_COUNT;
      data_count_r <= '0;
      data_pos_r   <= '0;
      addr_r       <= '0;
      type_r       <= '0;
      res_valid_r  <= 1'b0;
    end else begin
      if (res_pop) begin
        res_valid_r <= 1'b0;
      end
      if (byte_pop) begin
        unique case (stage_r)
          ST_ADDR_HI: begin
            addr_r[15:8] <= byte_item.value;
            stage_r      <= ST_ADDR_LO;
          end
          ST_ADDR_LO: begin
            addr_r[7:0] <= byte_item.value;
            stage_r     <= ST_TYPE;
          end
          ST_TYPE: begin
            type_r     <= byte_item.value;
            data_pos_r <= '0;
            stage_r    <= (data_count_r == '0) ? ST_CHECK : ST_DATA;
          end
          ST_DATA: begin
            res_valid_r          <= 1'b1;
            res_r.kind           <= KIND_DATA;
            res_r.byte_value     <= byte_item.value;
            res_r.record_type    <= type_r;
            res_r.record_address <= addr_r;
            res_r.byte_index     <= data_pos_r[3:0];
            res_r.bad_digit      <= byte_item.bad;
            data_pos_r           <= pos_inc;
            if (pos_inc >= data_count_r) begin
              stage_r <= ST_CHECK;
            end
          end
          ST_CHECK: begin
            res_valid_r          <= 1'b1;
            res_r.kind           <= KIND_CHECK;
            res_r.byte_value     <= byte_item.value;
            res_r.record_type    <= type_r;
            res_r.record_address <= addr_r;
            res_r.byte_index     <= 4'd0;
            res_r.bad_digit      <= byte_item.bad;
            stage_r              <= ST_COUNT;
          end
          default: begin
            if (byte_item.value > 8'(MAX_RECORD_BYTES)) begin
              data_count_r <= CNT_W'(byte_item.value[3:0]);
            end else begin
              data_count_r <= CNT_W'(byte_item.value);
            end
            stage_r <= ST_ADDR_HI;
          end
        endcase
      end
    end
  end

  a_check_closes: assert property (@(posedge clk) disable iff (!rst_n)
    byte_pop && (stage_r == ST_CHECK) |=> (stage_r == ST_COUNT) && res_valid_r
                                          && (res_r.kind == KIND_CHECK))
    else $error("checksum byte did not close the record");

  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (stage_r == ST_DATA) |-> (data_pos_r < data_count_r))
    else $error("data position beyond byte count");

  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    data_count_r <= CNT_W'(MAX_RECORD_BYTES))
    else $error("byte count above record limit");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r && !res_pop |=> res_valid_r && $stable(res_r))
    else $error("waiting result overwritten");

endmodule : ihex_back
`default_nettype wire

>>> hdl/intel_hex_record_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// intel_hex_record_parser
// Intel HEX text to data and checksum bytes with their record context.
// ----------------------------------------------------------------------------
// One character is taken per cycle while in_full is low, and one result can
// be taken per cycle; each data or checksum byte is registered as a result.
// Carriage return, line feed and colon are dropped; other characters pair
// into bytes, a non-hex character counting as zero with bad_digit set. The
// decoder feeds a two-entry byte queue, and the field sequencer holds one
// result register, so each side stalls only when its own neighbour stalls.
// ----------------------------------------------------------------------------
module intel_hex_record_parser (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_push,
  output logic        in_full,
  input  wire  [7:0]  in_char_in,
  output logic        out_empty,
  input  wire         out_pop,
  output logic        out_kind,
  output logic [7:0]  out_byte_value,
  output logic [7:0]  out_record_type,
  output logic [15:0] out_record_address,
  output logic [3:0]  out_byte_index,
  output logic        out_bad_digit
);
  import ihex_pkg::*;

  logic       char_valid;
  logic       q_push;
  byte_item_t q_in;
  logic       q_full;
  logic       q_valid;
  logic       q_pop;
  byte_item_t q_out;
  logic       res_valid;
  logic       res_pop;
  result_t    res;

  assign in_full    = q_full;
  assign char_valid = in_push && !q_full;
  assign out_empty  = !res_valid;
  assign res_pop    = out_pop && res_valid;

  ihex_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .char_valid (char_valid),
    .char_in    (in_char_in),
    .byte_push  (q_push),
    .byte_item  (q_in)
  );

  ihex_byte_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .valid     (q_valid),
    .pop       (q_pop),
    .pop_item  (q_out)
  );

  ihex_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (q_valid),
    .byte_item  (q_out),
    .byte_pop   (q_pop),
    .res_valid  (res_valid),
    .res_pop    (res_pop),
    .res        (res)
  );

  assign out_kind           = res.kind;
  assign out_byte_value     = res.byte_value;
  assign out_record_type    = res.record_type;
  assign out_record_address = res.record_address;
  assign out_byte_index     = res.byte_index;
  assign out_bad_digit      = res.bad_digit;

endmodule : intel_hex_record_parser
`default_nettype wire

>>> bench/tb_intel_hex_record_parser.sv
// ----------------------------------------------------------------------------
// tb_intel_hex_record_parser
// Self-checking bench for the Intel HEX record parser.
// ----------------------------------------------------------------------------
// Characters go in through the push/full queue port. A parser model in the
// bench tracks nibble pairing and the record fields, and queues the data and
// checksum bytes it expects. Each result popped from the block is checked
// field by field against the oldest expected byte. Directed records cover
// mixed case, bad digits, oversize and empty counts. Random records follow,
// mostly well formed, with noise and cut-off records mixed in, under random
// stalls on both sides and one stretch with no stalls.
// ----------------------------------------------------------------------------
module tb_intel_hex_record_parser;
  import ihex_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_CHARS = 950;
  localparam int QUIET_CHARS  = 350;
  localparam int IDLE_PCT     = 14;

  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_COLON   = ":";
  localparam logic [7:0] CH_ZERO    = "0";
  localparam logic [7:0] CH_NINE    = "9";
  localparam logic [7:0] CH_UPPER_A = "A";
  localparam logic [7:0] CH_UPPER_F = "F";
  localparam logic [7:0] CH_LOWER_A = "a";
  localparam logic [7:0] CH_LOWER_F = "f";

  typedef enum logic [2:0] {
    FLD_COUNT, FLD_ADDR_HI, FLD_ADDR_LO, FLD_TYPE, FLD_DATA, FLD_CHECK
  } field_e;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_push    = 1'b0;
  logic [7:0]  in_char_in = 8'h00;
  logic        out_pop    = 1'b0;
  logic        in_full;
  logic        out_empty;
  logic        out_kind;
  logic [7:0]  out_byte_value;
  logic [7:0]  out_record_type;
  logic [15:0] out_record_address;
  logic [3:0]  out_byte_index;
  logic        out_bad_digit;

  intel_hex_record_parser uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_char_in         (in_char_in),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_kind           (out_kind),
    .out_byte_value     (out_byte_value),
    .out_record_type    (out_record_type),
    .out_record_address (out_record_address),
    .out_byte_index     (out_byte_index),
    .out_bad_digit      (out_bad_digit)
  );

  always #5 clk = ~clk;

  // parser model state
  logic        mdl_second;
  logic [3:0]  mdl_high;
  field_e      mdl_stage;
  logic [4:0]  mdl_count;
  logic [4:0]  mdl_position;
  logic [15:0] mdl_address;
  logic [7:0]  mdl_type;
  logic        mdl_bad;

  result_t     expected_bytes[$];
  result_t     oldest;
  int          errors      = 0;
  int          cycle_count = 0;
  int          chars_sent  = 0;
  bit          quiet       = 1'b0;

  function automatic void parse_char(input logic [7:0] ch);
    logic [3:0] nib;
    logic       ok;
    logic [7:0] value;
    logic       bad;
    result_t    res;
    if (ch == CH_CR || ch == CH_LF || ch == CH_COLON) return;
    ok  = 1'b1;
    nib = 4'h0;
    if (ch >= CH_ZERO && ch <= CH_NINE) nib = 4'(ch - CH_ZERO);
    else if (ch >= CH_UPPER_A && ch <= CH_UPPER_F) nib = 4'(ch - CH_UPPER_A + 10);
    else if (ch >= CH_LOWER_A && ch <= CH_LOWER_F) nib = 4'(ch - CH_LOWER_A + 10);
    else ok = 1'b0;
    if (!mdl_second) begin
      mdl_high   = nib;
      mdl_bad    = !ok;
      mdl_second = 1'b1;
      return;
    end
    mdl_second = 1'b0;
    value      = {mdl_high, nib};
    bad        = mdl_bad | !ok;
    mdl_bad    = 1'b0;
    res.kind           = KIND_DATA;
    res.byte_value     = value;
    res.record_type    = mdl_type;
    res.record_address = mdl_address;
    res.byte_index     = 4'h0;
    res.bad_digit      = bad;
    case (mdl_stage)
      FLD_ADDR_HI: begin
        mdl_address[15:8] = value;
        mdl_stage = FLD_ADDR_LO;
      end
      FLD_ADDR_LO: begin
        mdl_address[7:0] = value;
        mdl_stage = FLD_TYPE;
      end
      FLD_TYPE: begin
        mdl_type     = value;
        mdl_position = 5'd0;
        mdl_stage    = (mdl_count == 5'd0) ? FLD_CHECK : FLD_DATA;
      end
      FLD_DATA: begin
        res.byte_index = mdl_position[3:0];
        expected_bytes.push_back(res);
        mdl_position = mdl_position + 5'd1;
        if (mdl_position >= mdl_count) mdl_stage = FLD_CHECK;
      end
      FLD_CHECK: begin
        res.kind = KIND_CHECK;
        expected_bytes.push_back(res);
        mdl_stage = FLD_COUNT;
      end
      default: begin
        mdl_count = (value > MAX_RECORD_BYTES) ? {1'b0, value[3:0]} : value[4:0];
        mdl_stage = FLD_ADDR_HI;
      end
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      mdl_second   <= 1'b0;
      mdl_high     <= 4'h0;
      mdl_stage    <= FLD_COUNT;
      mdl_count    <= 5'd0;
      mdl_position <= 5'd0;
      mdl_address  <= 16'h0000;
      mdl_type     <= 8'h00;
      mdl_bad      <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (expected_bytes.size() == 0) begin
          $error("out_byte_value: expected no transfer, actual %0h", out_byte_value);
          errors++;
        end else begin
          oldest = expected_bytes.pop_front();
          check_field("out_kind", oldest.kind, out_kind);
          check_field("out_byte_value", oldest.byte_value, out_byte_value);
          check_field("out_record_type", oldest.record_type, out_record_type);
          check_field("out_record_address", oldest.record_address, out_record_address);
          check_field("out_byte_index", oldest.byte_index, out_byte_index);
          check_field("out_bad_digit", oldest.bad_digit, out_bad_digit);
        end
      end
      if (in_push && !in_full) parse_char(in_char_in);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_pop <= 1'b0;
    else out_pop <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_char(input logic [7:0] ch);
    if (!quiet) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_push <= 1'b0;
        @(posedge clk);
      end
    end
    in_push    <= 1'b1;
    in_char_in <= ch;
    do @(posedge clk); while (in_full);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic wait_for_drain();
    in_push <= 1'b0;
    do @(posedge clk); while (expected_bytes.size() != 0);
  endtask

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    if (nib < 4'd10) return CH_ZERO + 8'(nib);
    if ($urandom_range(0, 1)) return CH_LOWER_A + 8'(nib) - 8'd10;
    return CH_UPPER_A + 8'(nib) - 8'd10;
  endfunction

  // replace a digit with an arbitrary character now and then
  task automatic send_hex_byte(input logic [7:0] b);
    send_char(($urandom_range(0, 99) < 2) ? 8'($urandom_range(0, 255)) : hex_digit(b[7:4]));
    send_char(($urandom_range(0, 99) < 2) ? 8'($urandom_range(0, 255)) : hex_digit(b[3:0]));
  endtask

  task automatic send_record();
    logic [7:0] count_byte;
    logic [7:0] sum;
    logic [7:0] b;
    int         n;
    int         total;
    int         cut;
    if ($urandom_range(0, 99) < 90) send_char(CH_COLON);
    count_byte = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, MAX_RECORD_BYTES))
                                              : 8'($urandom_range(0, 255));
    n     = (count_byte > MAX_RECORD_BYTES) ? count_byte[3:0] : count_byte;
    total = n + 5;
    cut   = ($urandom_range(0, 99) < 8) ? $urandom_range(0, total - 1) : total;
    sum   = 8'h00;
    for (int i = 0; i < cut; i++) begin
      if (i == 0) b = count_byte;
      else if (i == 3) b = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 5))
                                                       : 8'($urandom_range(0, 255));
      else if (i == total - 1) b = ($urandom_range(0, 99) < 70) ? -sum
                                                                : 8'($urandom_range(0, 255));
      else b = 8'($urandom_range(0, 255));
      sum = sum + b;
      send_hex_byte(b);
    end
    if (cut != total && $urandom_range(0, 1)) send_char(hex_digit(4'($urandom_range(0, 15))));
    if ($urandom_range(0, 3) != 0) send_char(CH_CR);
    send_char(CH_LF);
    if ($urandom_range(0, 99) < 5) begin
      repeat ($urandom_range(1, 4)) send_char(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_mixed_case_record();
    send_text("01ABcd0Fe5Aa");
  endtask

  task automatic test_bad_digits_oversize_count();
    send_char("1");
    send_char(CH_COLON);
    send_char("1");
    send_char(8'hFF);
    send_char("0");
    send_char("g");
    send_char("G");
    send_text("00");
    send_char(8'h00);
    send_char("7");
    send_char("9");
    send_char(CH_LF);
    send_char("9");
  endtask

  task automatic test_empty_record();
    send_text("\r00FFFF01FF");
  endtask

  task automatic test_drain_pause();
    repeat (3) begin
      send_record();
      wait_for_drain();
    end
  endtask

  task automatic test_random_records(input int target);
    int stop_at;
    stop_at = chars_sent + target;
    while (chars_sent < stop_at) send_record();
  endtask

  task automatic test_back_to_back(input int target);
    quiet = 1'b1;
    test_random_records(target);
    quiet = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_mixed_case_record();
    test_bad_digits_oversize_count();
    test_empty_record();
    test_drain_pause();
    test_random_records(RANDOM_CHARS / 2);
    test_back_to_back(QUIET_CHARS);
    test_random_records(RANDOM_CHARS / 2);
    wait_for_drain();
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_bytes.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
